FILE: rtl/desq_pkg.sv
// desq_pkg: shared types and constants of the delayed event slot queue
// used by desq_front, desq_cmd_fifo, desq_back and delayed_event_slot_queue
package desq_pkg;

  localparam int unsigned QueueSlotsDefault = 16;
  localparam int unsigned MaxResults        = 16;
  localparam int unsigned CmdDepth          = 2;

  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 48;

  localparam logic [1:0] ActNone = 2'd0;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] stamp;
    logic        kind;
    logic [7:0]  id;
    logic [1:0]  act;
    logic [31:0] dur;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  id;
    logic [1:0]  act;
    logic [31:0] dur;
  } res_t;

endpackage

FILE: rtl/delayed_event_slot_queue.sv
// delayed_event_slot_queue: top level, front, command queue and slot table
// depends on desq_pkg, desq_front, desq_cmd_fifo and desq_back
//
// A table of QUEUE_SLOTS timed events. An add item (tuser 0) stores its event
// in the lowest free slot with due time now_ms + delay_ms, or is dropped when
// the table is full; it yields no result. A tick item (tuser 1) scans the
// slots through the single read port of the slot memory, one slot a cycle
// while the output is not stalled. Due slots (wrap-safe, up to 2^31-1 ms
// late) are cleared; relay events with an action and all scene events give a
// result, at most 16 per tick, and the last one carries tlast. A two-entry
// command queue lets items be taken while a tick is being scanned. The slot
// table is empty after reset, with no clearing pass.
module delayed_event_slot_queue #(
  parameter int unsigned QUEUE_SLOTS = desq_pkg::QueueSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // now_ms[31:0], event_kind[32], target_id[40:33], relay_action[42:41],
  // delay_ms[74:43], on_duration_ms[106:75], zero fill
  input  logic [desq_pkg::InDataW-1:0]  s_axis_tdata_i,
  // operation[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // fired_kind[0], fired_id[8:1], fired_action[10:9],
  // fired_duration_ms[42:11], zero fill
  output logic [desq_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);

  logic           f_valid, f_ready;
  desq_pkg::cmd_t f_cmd;
  logic           b_valid, b_ready;
  desq_pkg::cmd_t b_cmd;
  desq_pkg::res_t res;

  desq_front u_front (
    .s_valid_i (s_axis_tvalid_i),
    .s_user_i  (s_axis_tuser_i),
    .s_data_i  (s_axis_tdata_i),
    .s_ready_o (s_axis_tready_o),
    .q_ready_i (f_ready),
    .q_valid_o (f_valid),
    .q_cmd_o   (f_cmd)
  );

  desq_cmd_fifo #(
    .DEPTH (desq_pkg::CmdDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_cmd_i   (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_cmd_o   (b_cmd)
  );

  desq_back #(
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b0, res.dur, res.act, res.id, res.kind};

endmodule

FILE: rtl/desq_front.sv
// desq_front: unpacks input items, works out due times of add items
// and hands commands to the queue; depends on desq_pkg
module desq_front (
  input  logic                              s_valid_i,
  input  logic                              s_user_i,
  input  logic [desq_pkg::InDataW-1:0]      s_data_i,
  output logic                              s_ready_o,
  input  logic                              q_ready_i,
  output logic                              q_valid_o,
  output desq_pkg::cmd_t                    q_cmd_o
);

  logic [31:0] now_ms;
  logic [31:0] delay_ms;

  assign now_ms   = s_data_i[31:0];
  assign delay_ms = s_data_i[74:43];

  always_comb begin
    q_cmd_o.op    = desq_pkg::op_e'(s_user_i);
    q_cmd_o.kind  = s_data_i[32];
    q_cmd_o.id    = s_data_i[40:33];
    q_cmd_o.act   = s_data_i[42:41];
    q_cmd_o.dur   = s_data_i[106:75];
    if (desq_pkg::op_e'(s_user_i) == desq_pkg::OP_ADD) begin
      q_cmd_o.stamp = now_ms + delay_ms;
    end else begin
      q_cmd_o.stamp = now_ms;
    end
  end

  assign q_valid_o = s_valid_i;
  assign s_ready_o = q_ready_i;

endmodule

FILE: rtl/desq_cmd_fifo.sv
// desq_cmd_fifo: short command queue between front and back
// depends on desq_pkg for the command type
module desq_cmd_fifo #(
  parameter int unsigned DEPTH = desq_pkg::CmdDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  desq_pkg::cmd_t wr_cmd_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output desq_pkg::cmd_t rd_cmd_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  desq_pkg::cmd_t   mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != NW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

endmodule

FILE: rtl/desq_back.sv
// desq_back: slot table, add placement and tick scan with result register
// depends on desq_pkg for command, result types and limits
module desq_back #(
  parameter int unsigned QUEUE_SLOTS = desq_pkg::QueueSlotsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  desq_pkg::cmd_t cmd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output desq_pkg::res_t out_res_o,
  output logic           out_last_o
);

  localparam int unsigned IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned FW = $clog2(desq_pkg::MaxResults + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [QUEUE_SLOTS-1:0] valid_q, valid_d;
  logic [CW-1:0]        iss_q, iss_d;
  logic                 rd_v_q, rd_v_d;
  logic [IW-1:0]        rd_idx_q, rd_idx_d;
  logic [31:0]          now_q, now_d;
  logic [FW-1:0]        found_q, found_d;
  logic                 pend_v_q, pend_v_d;
  desq_pkg::res_t       pend_q, pend_d;
  logic                 out_v_q, out_v_d;
  desq_pkg::res_t       out_q, out_d;
  logic                 last_q, last_d;

  desq_pkg::res_t       meta_mem [QUEUE_SLOTS];
  logic [31:0]          due_mem  [QUEUE_SLOTS];
  desq_pkg::res_t       rd_res_q;
  logic [31:0]          rd_due_q;

  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic                 wr_en;
  logic [IW-1:0]        free_idx;
  logic                 free_found;
  logic [31:0]          diff;
  logic                 hit, emit, stall, stop, out_free;
  desq_pkg::res_t       wr_res;

  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx   = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign diff     = now_q - rd_due_q;
  assign hit      = (state_q == ST_SCAN) && rd_v_q && valid_q[rd_idx_q] && !diff[31];
  assign emit     = hit && (rd_res_q.kind || (rd_res_q.act != desq_pkg::ActNone));
  assign out_free = !out_v_q || out_ready_i;
  assign stall    = emit && pend_v_q && !out_free;
  assign stop     = emit && (found_q == FW'(desq_pkg::MaxResults - 1));

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign wr_res.kind = cmd_i.kind;
  assign wr_res.id   = cmd_i.id;
  assign wr_res.act  = cmd_i.act;
  assign wr_res.dur  = cmd_i.dur;

  always_comb begin
    state_d  = state_q;
    valid_d  = valid_q;
    iss_d    = iss_q;
    rd_v_d   = rd_v_q;
    rd_idx_d = rd_idx_q;
    now_d    = now_q;
    found_d  = found_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q && !out_ready_i;
    out_d    = out_q;
    last_d   = last_q;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == desq_pkg::OP_ADD) begin
            if (free_found) begin
              wr_en             = 1'b1;
              valid_d[free_idx] = 1'b1;
            end
          end else begin
            now_d    = cmd_i.stamp;
            found_d  = '0;
            rd_en    = 1'b1;
            rd_addr  = '0;
            rd_idx_d = '0;
            rd_v_d   = 1'b1;
            iss_d    = CW'(1);
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (hit) begin
            valid_d[rd_idx_q] = 1'b0;
          end
          if (emit) begin
            if (pend_v_q) begin
              out_d   = pend_q;
              last_d  = 1'b0;
              out_v_d = 1'b1;
            end
            pend_d   = rd_res_q;
            pend_v_d = 1'b1;
            found_d  = found_q + 1'b1;
          end
          if (stop || (iss_q == CW'(QUEUE_SLOTS))) begin
            rd_v_d  = 1'b0;
            state_d = ST_FLUSH;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = iss_q[IW-1:0];
            rd_idx_d = iss_q[IW-1:0];
            rd_v_d   = 1'b1;
            iss_d    = iss_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_d    = pend_q;
          last_d   = 1'b1;
          out_v_d  = 1'b1;
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      iss_q    <= '0;
      rd_v_q   <= 1'b0;
      found_q  <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      iss_q    <= iss_d;
      rd_v_q   <= rd_v_d;
      found_q  <= found_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    now_q    <= now_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      meta_mem[free_idx] <= wr_res;
      due_mem[free_idx]  <= cmd_i.stamp;
    end
    if (rd_en) begin
      rd_res_q <= meta_mem[rd_addr];
      rd_due_q <= due_mem[rd_addr];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;
  assign out_last_o  = last_q;

endmodule
